// ===== sv/rgbgd_pkg.sv =====
package rgbgd_pkg;

  localparam int DIM_W = 12;
  localparam int COL_W = 11;
  localparam logic [DIM_W-1:0] MAX_DIM = 12'd2048;
  localparam int DIV_STEPS = DIM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [DIM_W-1:0] RST_SRC_W = 12'd320;
  localparam logic [DIM_W-1:0] RST_SRC_H = 12'd240;
  localparam logic [DIM_W-1:0] RST_DST_W = 12'd96;
  localparam logic [DIM_W-1:0] RST_DST_H = 12'd96;

  typedef enum logic [1:0] {
    CFG_SRC_W = 2'd0,
    CFG_SRC_H = 2'd1,
    CFG_DST_W = 2'd2,
    CFG_DST_H = 2'd3
  } cfg_reg_t;

  localparam logic [15:0] FULL_SCALE = 16'd255;
  localparam logic [15:0] RED_WEIGHT = 16'd30;
  localparam logic [15:0] GREEN_WEIGHT = 16'd59;
  localparam logic [15:0] BLUE_WEIGHT = 16'd11;

  // floor(x / 31) == (x * 8457) >> 18 for every x up to 7905, and
  // floor(x / 63) == (x * 16645) >> 20 for every x up to 16065.
  localparam int EXP_W = 30;
  localparam logic [14:0] RECIP_31 = 15'd8457;
  localparam int SHIFT_31 = 18;
  localparam logic [14:0] RECIP_63 = 15'd16645;
  localparam int SHIFT_63 = 20;

  // floor(s / 100) == (s * 5243) >> 19 for every s up to 25500.
  localparam int SUM_W = 15;
  localparam int RECIP_W = 13;
  localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
  localparam int RECIP_SHIFT = 19;

  function automatic logic [SUM_W-1:0] red_term(input logic [4:0] r);
    logic [15:0]      x;
    logic [EXP_W-1:0] p;
    logic [15:0]      e;
    x = 16'(r) * FULL_SCALE;
    p = EXP_W'(x) * EXP_W'(RECIP_31);
    e = 16'(p[SHIFT_31+7:SHIFT_31]);
    return SUM_W'(e * RED_WEIGHT);
  endfunction

  function automatic logic [SUM_W-1:0] green_term(input logic [5:0] g);
    logic [15:0]      x;
    logic [EXP_W-1:0] p;
    logic [15:0]      e;
    x = 16'(g) * FULL_SCALE;
    p = EXP_W'(x) * EXP_W'(RECIP_63);
    e = 16'(p[SHIFT_63+7:SHIFT_63]);
    return SUM_W'(e * GREEN_WEIGHT);
  endfunction

  function automatic logic [SUM_W-1:0] blue_term(input logic [4:0] b);
    logic [15:0]      x;
    logic [EXP_W-1:0] p;
    logic [15:0]      e;
    x = 16'(b) * FULL_SCALE;
    p = EXP_W'(x) * EXP_W'(RECIP_31);
    e = 16'(p[SHIFT_31+7:SHIFT_31]);
    return SUM_W'(e * BLUE_WEIGHT);
  endfunction

  function automatic logic [DIM_W-1:0] eff_src(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] res;
    res = v;
    if (v == '0) res = DIM_W'(1);
    else if (v > MAX_DIM) res = MAX_DIM;
    return res;
  endfunction

  function automatic logic [DIM_W-1:0] eff_dst(input logic [DIM_W-1:0] v,
                                               input logic [DIM_W-1:0] src);
    logic [DIM_W-1:0] res;
    res = v;
    if (v == '0) res = DIM_W'(1);
    else if (v > src) res = src;
    return res;
  endfunction

endpackage

// ===== sv/rgbgd_div.sv =====
module rgbgd_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [rgbgd_pkg::DIM_W-1:0]   dividend,
  input  logic [rgbgd_pkg::DIM_W-1:0]   divisor,
  output logic [rgbgd_pkg::DIM_W-1:0]   quotient,
  output logic [rgbgd_pkg::DIM_W-1:0]   remainder,
  output logic                          busy
);
  import rgbgd_pkg::*;

  logic [DIV_CNT_W-1:0] count;
  logic [DIM_W-1:0]     quot;
  logic [DIM_W-1:0]     rem;
  logic [DIM_W:0]       shifted;
  logic [DIM_W:0]       diff;

  assign shifted = {rem, quot[DIM_W-1]};
  assign diff = shifted - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= DIV_CNT_W'(DIV_STEPS);
    end else if (count != '0) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
    end else if (count != '0) begin
      if (!diff[DIM_W]) begin
        rem  <= diff[DIM_W-1:0];
        quot <= {quot[DIM_W-2:0], 1'b1};
      end else begin
        rem  <= shifted[DIM_W-1:0];
        quot <= {quot[DIM_W-2:0], 1'b0};
      end
    end
  end

  assign quotient  = quot;
  assign remainder = rem;
  assign busy      = count != '0;

endmodule

// ===== sv/rgb565_gray_nearest_downscaler_top.sv =====
// Channel   Direction  Handshake          Payload
// in        sink       in_valid/in_ready  rgb_pixel[15:0]
// out       source     out_valid/out_ready gray_value[7:0], frame_end
// cfg       sink       cfg_write          cfg_index[1:0], cfg_data[11:0]
//
// While in_ready is high one request is taken per cycle, and kept pixels go through s1.
// Pixels that are not kept produce no result and are absorbed in the cycle they arrive.
// After reset and after every register write, the step quotients are recomputed by a
// shift-subtract divider: a load and then 12 steps, with in_ready low until they finish.
// A stalled output holds its result; the input register still takes requests until it
// holds a kept pixel, and then in_ready stays low until the output is taken.
module rgb565_gray_nearest_downscaler_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] rgb_pixel,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  gray_value,
  output logic        frame_end,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);
  import rgbgd_pkg::*;

  logic [DIM_W-1:0] source_width;
  logic [DIM_W-1:0] source_height;
  logic [DIM_W-1:0] target_width;
  logic [DIM_W-1:0] target_height;

  logic [DIM_W-1:0] sw_e, sh_e, tw_e, th_e;
  logic [DIM_W-1:0] q_w, r_w, q_h, r_h;
  logic             busy_w, busy_h, div_load, busy;

  logic [COL_W-1:0] src_col, src_col_next;
  logic [COL_W-1:0] src_row, src_row_next;
  logic [DIM_W-1:0] dst_col, dst_col_next;
  logic [DIM_W-1:0] dst_row, dst_row_next;
  logic [DIM_W-1:0] next_keep_col, next_keep_col_next;
  logic [DIM_W-1:0] col_remainder, col_remainder_next;
  logic [DIM_W-1:0] next_keep_row, next_keep_row_next;
  logic [DIM_W-1:0] row_remainder, row_remainder_next;

  logic             in_fire, keep_row, keep, last, col_end, row_end;
  logic [DIM_W:0]   col_m, row_m;

  logic             s1_valid, s1_adv, s1_last;
  logic [15:0]      s1_pixel;
  logic [SUM_W-1:0] sum;
  logic [SUM_W+RECIP_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= RST_SRC_W;
      source_height <= RST_SRC_H;
      target_width  <= RST_DST_W;
      target_height <= RST_DST_H;
      div_load      <= 1'b1;
    end else begin
      div_load <= cfg_write;
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          CFG_SRC_W: source_width  <= cfg_data;
          CFG_SRC_H: source_height <= cfg_data;
          CFG_DST_W: target_width  <= cfg_data;
          CFG_DST_H: target_height <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign sw_e = eff_src(source_width);
  assign sh_e = eff_src(source_height);
  assign tw_e = eff_dst(target_width, sw_e);
  assign th_e = eff_dst(target_height, sh_e);

  rgbgd_div u_div_w (
    .clk(clk), .rst(rst), .start(div_load), .dividend(sw_e), .divisor(tw_e),
    .quotient(q_w), .remainder(r_w), .busy(busy_w)
  );

  rgbgd_div u_div_h (
    .clk(clk), .rst(rst), .start(div_load), .dividend(sh_e), .divisor(th_e),
    .quotient(q_h), .remainder(r_h), .busy(busy_h)
  );

  assign busy     = div_load || busy_w || busy_h;
  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !busy && !cfg_write && (!s1_valid || s1_adv);
  assign in_fire  = in_valid && in_ready;

  assign keep_row = (dst_row < th_e) && ({1'b0, src_row} == next_keep_row);
  assign keep     = keep_row && (dst_col < tw_e) && ({1'b0, src_col} == next_keep_col);
  assign last     = (dst_row == th_e - 1'b1) && (dst_col == tw_e - 1'b1);
  assign col_end  = {1'b0, src_col} >= sw_e - 1'b1;
  assign row_end  = {1'b0, src_row} >= sh_e - 1'b1;
  assign col_m    = {1'b0, col_remainder} + {1'b0, r_w};
  assign row_m    = {1'b0, row_remainder} + {1'b0, r_h};

  always_comb begin
    src_col_next       = src_col;
    src_row_next       = src_row;
    dst_col_next       = dst_col;
    dst_row_next       = dst_row;
    next_keep_col_next = next_keep_col;
    col_remainder_next = col_remainder;
    next_keep_row_next = next_keep_row;
    row_remainder_next = row_remainder;
    if (keep) begin
      dst_col_next = dst_col + 1'b1;
      if (col_m >= {1'b0, tw_e}) begin
        col_remainder_next = DIM_W'(col_m - {1'b0, tw_e});
        next_keep_col_next = next_keep_col + q_w + 1'b1;
      end else begin
        col_remainder_next = col_m[DIM_W-1:0];
        next_keep_col_next = next_keep_col + q_w;
      end
    end
    if (col_end) begin
      src_col_next       = '0;
      dst_col_next       = '0;
      next_keep_col_next = '0;
      col_remainder_next = '0;
      if (keep_row) begin
        dst_row_next = dst_row + 1'b1;
        if (row_m >= {1'b0, th_e}) begin
          row_remainder_next = DIM_W'(row_m - {1'b0, th_e});
          next_keep_row_next = next_keep_row + q_h + 1'b1;
        end else begin
          row_remainder_next = row_m[DIM_W-1:0];
          next_keep_row_next = next_keep_row + q_h;
        end
      end
      if (row_end) begin
        src_row_next       = '0;
        dst_row_next       = '0;
        next_keep_row_next = '0;
        row_remainder_next = '0;
      end else begin
        src_row_next = src_row + 1'b1;
      end
    end else begin
      src_col_next = src_col + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_col       <= '0;
      src_row       <= '0;
      dst_col       <= '0;
      dst_row       <= '0;
      next_keep_col <= '0;
      col_remainder <= '0;
      next_keep_row <= '0;
      row_remainder <= '0;
    end else if (in_fire) begin
      src_col       <= src_col_next;
      src_row       <= src_row_next;
      dst_col       <= dst_col_next;
      dst_row       <= dst_row_next;
      next_keep_col <= next_keep_col_next;
      col_remainder <= col_remainder_next;
      next_keep_row <= next_keep_row_next;
      row_remainder <= row_remainder_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= keep;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && keep) begin
      s1_pixel <= rgb_pixel;
      s1_last  <= last;
    end
  end

  assign sum  = red_term(s1_pixel[15:11]) + green_term(s1_pixel[10:5])
              + blue_term(s1_pixel[4:0]);
  assign prod = (SUM_W+RECIP_W)'(sum) * (SUM_W+RECIP_W)'(RECIP_100);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      gray_value <= prod[RECIP_SHIFT+7:RECIP_SHIFT];
      frame_end  <= s1_last;
    end
  end

`ifndef SYNTHESIS
  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_ready)
    else $error("request accepted while step quotients are being computed");

  a_div_width: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (24'(q_w) * 24'(tw_e) + 24'(r_w) == 24'(sw_e)))
    else $error("column step quotient does not match the configured sizes");

  a_div_height: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (24'(q_h) * 24'(th_e) + 24'(r_h) == 24'(sh_e)))
    else $error("row step quotient does not match the configured sizes");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid && $stable(s1_pixel))
    else $error("input register lost a kept pixel under output stall");

  a_col_wrap: assert property (@(posedge clk) disable iff (rst)
    in_fire && col_end |=> src_col == '0 && dst_col == '0)
    else $error("column counters did not wrap at the end of a source row");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import rgbgd_pkg::*;

  typedef struct {
    logic [7:0] gray;
    logic       last;
  } gray_result_t;

  class gray_tracker;
    logic [DIM_W-1:0] src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
    logic [COL_W-1:0] col, row;
    logic [11:0] out_col, out_row;
    logic [11:0] keep_col, col_frac, keep_row_at, row_frac;
    gray_result_t pending[$];
    int errors;

    function new();
      src_w_reg = RST_SRC_W;
      src_h_reg = RST_SRC_H;
      dst_w_reg = RST_DST_W;
      dst_h_reg = RST_DST_H;
      col = '0;
      row = '0;
      out_col = '0;
      out_row = '0;
      keep_col = '0;
      col_frac = '0;
      keep_row_at = '0;
      row_frac = '0;
      errors = 0;
    endfunction

    function void set_size(cfg_reg_t idx, logic [DIM_W-1:0] v);
      case (idx)
        CFG_SRC_W: src_w_reg = v;
        CFG_SRC_H: src_h_reg = v;
        CFG_DST_W: dst_w_reg = v;
        CFG_DST_H: dst_h_reg = v;
        default: ;
      endcase
    endfunction

    // Moves a sampling position on by src/dst, carrying the remainder.
    function logic [23:0] step_target(logic [11:0] pos, logic [11:0] frac,
                                      int unsigned src, int unsigned dst);
      int unsigned p, m;
      p = pos + src / dst;
      m = frac + src % dst;
      if (m >= dst) begin
        m = m - dst;
        p = p + 1;
      end
      return {12'(p), 12'(m)};
    endfunction

    function void take_pixel(logic [15:0] px);
      int unsigned sw, sh, tw, th, r, g, b;
      bit row_hit, hit;
      gray_result_t res;
      sw = (src_w_reg == '0) ? 1 : ((src_w_reg > MAX_DIM) ? MAX_DIM : src_w_reg);
      sh = (src_h_reg == '0) ? 1 : ((src_h_reg > MAX_DIM) ? MAX_DIM : src_h_reg);
      tw = (dst_w_reg == '0) ? 1 : ((dst_w_reg > sw) ? sw : dst_w_reg);
      th = (dst_h_reg == '0) ? 1 : ((dst_h_reg > sh) ? sh : dst_h_reg);
      row_hit = (out_row < th) && (row == keep_row_at);
      hit = row_hit && (out_col < tw) && (col == keep_col);
      if (hit) begin
        r = px[15:11];
        g = px[10:5];
        b = px[4:0];
        r = r * 255 / 31;
        g = g * 255 / 63;
        b = b * 255 / 31;
        res.gray = 8'((r * 30 + g * 59 + b * 11) / 100);
        res.last = (out_row == th - 1) && (out_col == tw - 1);
        pending.push_back(res);
        out_col = out_col + 1'b1;
        {keep_col, col_frac} = step_target(keep_col, col_frac, sw, tw);
      end
      if (col >= sw - 1) begin
        col = '0;
        out_col = '0;
        keep_col = '0;
        col_frac = '0;
        if (row_hit) begin
          out_row = out_row + 1'b1;
          {keep_row_at, row_frac} = step_target(keep_row_at, row_frac, sh, th);
        end
        if (row >= sh - 1) begin
          row = '0;
          out_row = '0;
          keep_row_at = '0;
          row_frac = '0;
        end else begin
          row = row + 1'b1;
        end
      end else begin
        col = col + 1'b1;
      end
    endfunction

    function void match_gray(logic [7:0] gray, logic last);
      gray_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, got gray %0d frame_end %0b",
                 $time, gray, last);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (gray !== want.gray) begin
        $display("%0t: gray_value expected %0d, got %0d", $time, want.gray, gray);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: frame_end expected %0b, got %0b", $time, want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] rgb_pixel;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  gray_value;
  logic        frame_end;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [11:0] cfg_data;

  gray_tracker tracker;
  bit calm;
  int sent;

  rgb565_gray_nearest_downscaler_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rgb_pixel  (rgb_pixel),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .gray_value (gray_value),
    .frame_end  (frame_end),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("rgb565_gray_nearest_downscaler_top regression: fail");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 28);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      tracker.match_gray(gray_value, frame_end);
    end
  end

  task automatic send_pixel(input logic [15:0] px);
    while (!calm && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rgb_pixel <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.take_pixel(px);
    sent++;
  endtask

  task automatic put_reg(input cfg_reg_t idx, input logic [11:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    tracker.set_size(idx, v);
  endtask

  // Registers change only once every outstanding request has produced its result.
  task automatic resize(input logic [11:0] sw, input logic [11:0] sh,
                        input logic [11:0] tw, input logic [11:0] th);
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    put_reg(CFG_SRC_W, sw);
    put_reg(CFG_SRC_H, sh);
    put_reg(CFG_DST_W, tw);
    put_reg(CFG_DST_H, th);
    cfg_write <= 1'b0;
  endtask

  initial begin
    logic [15:0] corner_pixels [12];
    int sw, sh, tw, th, n, waited;
    corner_pixels = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07E0, 16'h001F, 16'h0821,
                      16'h8410, 16'h7BEF, 16'hAAAA, 16'h5555, 16'hFFDF, 16'h0001};
    tracker = new();
    calm = 1'b0;
    sent = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    rgb_pixel = '0;
    out_ready = 1'b0;
    cfg_write = 1'b0;
    cfg_index = CFG_SRC_W;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    resize(12'd4, 12'd3, 12'd4, 12'd3);
    foreach (corner_pixels[i]) send_pixel(corner_pixels[i]);
    resize(12'd0, 12'd0, 12'd0, 12'd0);
    repeat (3) send_pixel(16'($urandom));
    resize(12'd3, 12'd2, 12'hFFF, 12'd9);
    repeat (6) send_pixel(16'($urandom));
    resize(12'hFFF, 12'hFFF, 12'hFFF, 12'd0);
    repeat (4) send_pixel(16'($urandom));

    while (sent < 1275) begin
      calm <= (sent >= 500) && (sent < 750);
      if ($urandom_range(11) == 0) begin
        sw = $urandom_range(2048, 4095);
        sh = $urandom_range(1, 4095);
        tw = $urandom_range(0, 4095);
        th = $urandom_range(0, 4095);
        n = $urandom_range(1, 40);
      end else begin
        sw = $urandom_range(1, 12);
        sh = $urandom_range(1, 10);
        tw = ($urandom_range(9) == 0) ? $urandom_range(0, 4095) : $urandom_range(1, sw);
        th = ($urandom_range(9) == 0) ? $urandom_range(0, 4095) : $urandom_range(1, sh);
        n = sw * sh * $urandom_range(1, 3);
        if ($urandom_range(4) == 0) n = $urandom_range(1, 30);
      end
      resize(12'(sw), 12'(sh), 12'(tw), 12'(th));
      repeat (n) begin
        if ($urandom_range(7) == 0) send_pixel($urandom_range(1) ? 16'hFFFF : 16'h0000);
        else send_pixel(16'($urandom));
      end
    end

    in_valid <= 1'b0;
    waited = 0;
    while (tracker.pending.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (tracker.pending.size() != 0) begin
      $display("%0t: %0d results expected, got none", $time, tracker.pending.size());
      tracker.errors += tracker.pending.size();
    end
    if (tracker.errors == 0) begin
      $display("rgb565_gray_nearest_downscaler_top regression: pass");
    end else begin
      $display("rgb565_gray_nearest_downscaler_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== rgb565_gray_nearest_downscaler_top.f =====
sv/rgbgd_pkg.sv
sv/rgbgd_div.sv
sv/rgb565_gray_nearest_downscaler_top.sv
tb/sv/tb.sv
